/* design/toht_pkg.sv */
// ----------------------------------------------------------------------------
// Occlusion history table package
// Shared sizes, field codes and payload types of the occlusion history table.
// ----------------------------------------------------------------------------
package toht_pkg;

    // Number of history slots in the entry RAM.
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    // Wide enough to hold ENTRIES itself (scan pointer and high-water mark).
    localparam int CNT_W   = IDX_W + 1;

    // Opcodes.
    localparam logic [1:0] OP_APPLY = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_CONFIRM = 2'd1;
    localparam logic [1:0] CFG_MAX_HID = 2'd2;

    // Smallest effective limits.
    localparam logic [7:0] MIN_CONFIRM = 8'd2;
    localparam logic [7:0] MIN_MAX_HID = 8'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] object_key;
        logic [63:0] xform_hash;
        logic        seen;
        logic [31:0] result_gen;
    } t_in;

    typedef struct packed {
        logic        draw;
        logic        applied;
        logic        table_full;
        logic [31:0] current_gen;
    } t_out;

    // One slot of the entry RAM.
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] hash;
        logic [7:0]  occ;
        logic [7:0]  hid;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* design/toht_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module toht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/temporal_occlusion_history_table_core.sv */
// ----------------------------------------------------------------------------
// Temporal occlusion history table core
// Per-object occlusion history keyed by a 64-bit object key, with apply,
// draw-query and clear operations, held in one synchronous entry RAM.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one result transfer
// per input transfer. Clear, stale or disabled applies, disabled queries and
// undefined opcodes skip the walk and go straight to S_FINISH. Applies and
// queries on an enabled block walk the entry RAM one slot per cycle through
// its single read port, starting at slot 0 and stopping at the first slot
// whose key matches; the walk never goes past the high-water mark of slots
// allocated since the last clear. Slot valid bits live in flip-flops, so
// reset and clear take effect at once and no clearing pass is needed. A
// finished result waits in an output register, and the next item is
// already accepted while it does.
// ----------------------------------------------------------------------------
module temporal_occlusion_history_table_core
    import toht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Item input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    // Result output
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    // Configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_top, n_top;
    logic [31:0]        r_gen, n_gen;
    logic               r_en, n_en;
    logic [7:0]         r_confirm, n_confirm;
    logic [7:0]         r_max_hid, n_max_hid;
    logic               r_out_valid, n_out_valid;
    logic               r_pend, n_pend;

    // Item and scan payload.
    t_in                r_item, n_item;
    logic               r_scan, n_scan;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic               r_pend_vld, n_pend_vld;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic               r_free_ok, n_free_ok;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    t_entry             r_ent, n_ent;
    t_out               r_out, n_out;

    // Entry RAM ports.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    t_entry             ram_rdata;

    // Working values of the finishing step.
    logic               in_xfer;
    logic               slot_free;
    logic               issue;
    logic               hit_now;
    logic [7:0]         eff_confirm;
    logic [7:0]         eff_max_hid;
    logic [IDX_W-1:0]   f_idx;
    t_entry             f_ent;
    logic               f_ok;
    logic [8:0]         f_occ_inc;

    toht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // Limits below their floors act as the floor.
    assign eff_confirm = (r_confirm < MIN_CONFIRM) ? MIN_CONFIRM : r_confirm;
    assign eff_max_hid = (r_max_hid < MIN_MAX_HID) ? MIN_MAX_HID : r_max_hid;

    // A read issued last cycle is compared against the item key now.
    assign hit_now = r_pend && r_pend_vld && (ram_rdata.key == r_item.object_key);
    // Keep issuing reads until the high-water mark or a hit.
    assign issue   = (r_state == S_SCAN) && (r_addr < r_top) && !hit_now;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_top       = r_top;
        n_gen       = r_gen;
        n_en        = r_en;
        n_confirm   = r_confirm;
        n_max_hid   = r_max_hid;
        n_out_valid = r_out_valid;
        n_pend      = r_pend;
        n_item      = r_item;
        n_scan      = r_scan;
        n_addr      = r_addr;
        n_pend_idx  = r_pend_idx;
        n_pend_vld  = r_pend_vld;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_ent       = r_ent;
        n_out       = r_out;

        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_ent;

        f_idx     = '0;
        f_ent     = r_ent;
        f_ok      = 1'b0;
        f_occ_inc = '0;

        // Configuration writes; indexes beyond the register list are dropped.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLED: n_en      = i_cfg_data[0];
                CFG_CONFIRM: n_confirm = i_cfg_data;
                CFG_MAX_HID: n_max_hid = i_cfg_data;
                default: ;
            endcase
        end

        // The output register drains on a result transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item    = i_in_data;
                    n_addr    = '0;
                    n_pend    = 1'b0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_scan    = r_en && ((i_in_data.opcode == OP_QUERY) ||
                                ((i_in_data.opcode == OP_APPLY) &&
                                 (i_in_data.result_gen == r_gen)));
                    n_state   = n_scan ? S_SCAN : S_FINISH;
                end
            end

            S_SCAN: begin
                n_pend = issue;
                if (issue) begin
                    ram_re     = 1'b1;
                    n_pend_idx = r_addr[IDX_W-1:0];
                    n_pend_vld = r_valid[r_addr[IDX_W-1:0]];
                    n_addr     = r_addr + 1'b1;
                    // Remember the lowest free slot for a possible insert.
                    if (!r_valid[r_addr[IDX_W-1:0]] && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_addr[IDX_W-1:0];
                    end
                end
                if (hit_now) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_pend_idx;
                    n_ent     = ram_rdata;
                    n_state   = S_FINISH;
                end else if (!(r_addr < r_top)) begin
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                if (slot_free) begin
                    n_out             = '0;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                    case (r_item.opcode)
                        OP_APPLY: begin
                            if (r_scan) begin
                                if (r_hit) begin
                                    f_idx = r_hit_idx;
                                    f_ent = r_ent;
                                    f_ok  = 1'b1;
                                end else if (r_free_ok || (r_top < CNT_W'(ENTRIES))) begin
                                    // New key: lowest free slot, else the next
                                    // slot above the high-water mark.
                                    f_idx = r_free_ok ? r_free_idx : r_top[IDX_W-1:0];
                                    f_ok  = 1'b1;
                                    f_ent = '{key:  r_item.object_key,
                                              hash: r_item.xform_hash,
                                              occ:  8'd0,
                                              hid:  8'd0};
                                    n_valid[f_idx] = 1'b1;
                                    if ({1'b0, f_idx} == r_top) begin
                                        n_top = r_top + 1'b1;
                                    end
                                end
                                if (f_ok) begin
                                    if (f_ent.hash != r_item.xform_hash) begin
                                        f_ent.hash = r_item.xform_hash;
                                        f_ent.occ  = 8'd0;
                                        f_ent.hid  = 8'd0;
                                    end
                                    if (r_item.seen) begin
                                        f_ent.occ = 8'd0;
                                        f_ent.hid = 8'd0;
                                    end else begin
                                        f_occ_inc = {1'b0, f_ent.occ} + 9'd1;
                                        f_ent.occ = (f_occ_inc < {1'b0, eff_confirm}) ?
                                                    f_occ_inc[7:0] : eff_confirm;
                                    end
                                    ram_we        = 1'b1;
                                    ram_waddr     = f_idx;
                                    ram_wdata     = f_ent;
                                    n_out.applied = 1'b1;
                                end else begin
                                    n_out.table_full = 1'b1;
                                end
                            end
                        end
                        OP_QUERY: begin
                            n_out.draw = 1'b1;
                            if (r_scan && r_hit) begin
                                f_ent = r_ent;
                                if (r_ent.hash != r_item.xform_hash) begin
                                    // Moved object: drop its history.
                                    n_valid[r_hit_idx] = 1'b0;
                                end else if (r_ent.occ < eff_confirm) begin
                                    n_out.draw = 1'b1;
                                end else if (r_ent.hid >= eff_max_hid) begin
                                    // Hidden long enough: force a redraw.
                                    f_ent.occ = 8'd0;
                                    f_ent.hid = 8'd0;
                                    ram_we    = 1'b1;
                                end else begin
                                    f_ent.hid  = r_ent.hid + 8'd1;
                                    ram_we     = 1'b1;
                                    n_out.draw = 1'b0;
                                end
                                ram_waddr = r_hit_idx;
                                ram_wdata = f_ent;
                            end
                        end
                        OP_CLEAR: begin
                            n_valid = '0;
                            n_top   = '0;
                            n_gen   = r_gen + 32'd1;
                        end
                        default: ;
                    endcase
                    n_out.current_gen = n_gen;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_top       <= '0;
            r_gen       <= '0;
            r_en        <= 1'b0;
            r_confirm   <= MIN_CONFIRM;
            r_max_hid   <= MIN_MAX_HID;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_top       <= n_top;
            r_gen       <= n_gen;
            r_en        <= n_en;
            r_confirm   <= n_confirm;
            r_max_hid   <= n_max_hid;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_scan     <= n_scan;
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_pend_vld <= n_pend_vld;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_ent      <= n_ent;
        r_out      <= n_out;
    end

endmodule

/* design/toht_chk.sv */
// ----------------------------------------------------------------------------
// Occlusion history table port checker
// Checks result handshake, result flags and single-item input at top ports.
// ----------------------------------------------------------------------------
module toht_chk
    import toht_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // A pending result stays until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before its transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    // At most one of draw, applied and table_full describes a result.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_data.draw, o_out_data.applied,
                                  o_out_data.table_full}))
        else $error("conflicting result flags");

    // Items are handled one at a time: no back-to-back input transfers.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in progress");

endmodule

bind temporal_occlusion_history_table_core toht_chk u_toht_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/toht_history_check.sv */
// ----------------------------------------------------------------------------
// Occlusion history table result checker
// Watches the item, result and register write channels of the occlusion
// history table, keeps its own copy of the history table to work out each
// expected result, and compares every result transfer against it.
// ----------------------------------------------------------------------------
module toht_history_check
    import toht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in        i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out       i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    // Shadow copy of the history table and the registers.
    logic        slot_used [ENTRIES];
    logic [63:0] slot_key  [ENTRIES];
    logic [63:0] slot_hash [ENTRIES];
    logic [7:0]  slot_occ  [ENTRIES];
    logic [7:0]  slot_hid  [ENTRIES];
    logic [31:0] gen_q;
    logic        enabled_q;
    logic [7:0]  confirm_q;
    logic [7:0]  max_hid_q;

    t_out expected_results [$];
    int   mismatch_cnt = 0;

    function automatic int lookup_slot(input logic [63:0] key);
        int slot;
        slot = -1;
        for (int i = 0; i < ENTRIES && slot < 0; i++) begin
            if (slot_used[i] && slot_key[i] == key) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    // Works out the result of one item and updates the shadow table.
    function automatic t_out occlusion_step(input t_in item);
        t_out       res;
        int         slot;
        logic [7:0] lim_confirm;
        logic [7:0] lim_hidden;
        logic [8:0] next_occ;
        res         = '0;
        lim_confirm = (confirm_q < MIN_CONFIRM) ? MIN_CONFIRM : confirm_q;
        lim_hidden  = (max_hid_q < MIN_MAX_HID) ? MIN_MAX_HID : max_hid_q;
        case (item.opcode)
            OP_APPLY: begin
                if (enabled_q && item.result_gen == gen_q) begin
                    slot = lookup_slot(item.object_key);
                    if (slot < 0) begin
                        // A new key takes the lowest free slot.
                        for (int i = 0; i < ENTRIES && slot < 0; i++) begin
                            if (!slot_used[i]) begin
                                slot = i;
                            end
                        end
                        if (slot >= 0) begin
                            slot_used[slot] = 1'b1;
                            slot_key[slot]  = item.object_key;
                            slot_hash[slot] = item.xform_hash;
                            slot_occ[slot]  = '0;
                            slot_hid[slot]  = '0;
                        end
                    end
                    if (slot < 0) begin
                        res.table_full = 1'b1;
                    end else begin
                        if (slot_hash[slot] != item.xform_hash) begin
                            slot_hash[slot] = item.xform_hash;
                            slot_occ[slot]  = '0;
                            slot_hid[slot]  = '0;
                        end
                        if (item.seen) begin
                            slot_occ[slot] = '0;
                            slot_hid[slot] = '0;
                        end else begin
                            // The count may sit above a lowered limit, so clamp.
                            next_occ       = {1'b0, slot_occ[slot]} + 9'd1;
                            slot_occ[slot] = (next_occ < {1'b0, lim_confirm}) ?
                                             next_occ[7:0] : lim_confirm;
                        end
                        res.applied = 1'b1;
                    end
                end
            end
            OP_QUERY: begin
                res.draw = 1'b1;
                if (enabled_q) begin
                    slot = lookup_slot(item.object_key);
                    if (slot >= 0) begin
                        if (slot_hash[slot] != item.xform_hash) begin
                            slot_used[slot] = 1'b0;
                        end else if (slot_occ[slot] < lim_confirm) begin
                            res.draw = 1'b1;
                        end else if (slot_hid[slot] >= lim_hidden) begin
                            slot_occ[slot] = '0;
                            slot_hid[slot] = '0;
                        end else begin
                            slot_hid[slot] = slot_hid[slot] + 8'd1;
                            res.draw       = 1'b0;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    slot_used[i] = 1'b0;
                end
                gen_q = gen_q + 32'd1;
            end
            default: begin
            end
        endcase
        res.current_gen = gen_q;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $realtime, name, exp_val, got_val);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
            end
            gen_q     = '0;
            enabled_q = 1'b0;
            confirm_q = MIN_CONFIRM;
            max_hid_q = MIN_MAX_HID;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLED: enabled_q = i_cfg_data[0];
                    CFG_CONFIRM: confirm_q = i_cfg_data;
                    CFG_MAX_HID: max_hid_q = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $realtime, i_out_data);
                    mismatch_cnt++;
                end else begin
                    exp_res = expected_results.pop_front();
                    report_field("draw", 32'(exp_res.draw), 32'(i_out_data.draw));
                    report_field("applied", 32'(exp_res.applied),
                                 32'(i_out_data.applied));
                    report_field("table_full", 32'(exp_res.table_full),
                                 32'(i_out_data.table_full));
                    report_field("current_gen", exp_res.current_gen,
                                 i_out_data.current_gen);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(occlusion_step(i_in_data));
            end
        end
        o_pending = expected_results.size();
        o_errors  = mismatch_cnt;
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Occlusion history table testbench
// Drives directed and random apply, query and clear items through the core
// under several register settings, with random gaps on both channels, a long
// result stall and a table fill past capacity; a checker beside the core
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import toht_pkg::*;

    // Codes that the package leaves unnamed: the spare opcode and register index.
    localparam logic [1:0] OP_UNDEF   = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int POOL        = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int FILL_ITEMS  = ENTRIES + 10;
    // Watchdog limit on the run length, in cycles.
    localparam int CYCLE_LIMIT = 1000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    int chk_errors;
    int chk_pending;
    int cycle_cnt = 0;

    // Generation the core should hold, advanced by every clear that we send.
    logic [31:0] gen_now = '0;
    // When set, neither side inserts idle cycles.
    logic        no_idle = 1'b0;
    // Asks the result side for one long stall.
    logic        hold_out = 1'b0;

    // A small pool of objects, so that applies and queries hit the same entries.
    logic [63:0] pool_key  [POOL];
    logic [63:0] pool_hash [POOL];
    logic [63:0] fill_key  [FILL_ITEMS];
    logic [63:0] fill_hash [FILL_ITEMS];

    temporal_occlusion_history_table_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    toht_history_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // Offers one item after a random gap and returns at the falling edge after
    // its transfer. Valid stays high across back-to-back items, so it gets only
    // one assignment per edge.
    task automatic send_op(input logic [1:0] op, input logic [63:0] key,
                           input logic [63:0] hash, input logic seen,
                           input logic [31:0] gen);
        int  gap;
        t_in item;
        gap             = draw_gap();
        item.opcode     = op;
        item.object_key = key;
        item.xform_hash = hash;
        item.seen       = seen;
        item.result_gen = gen;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (op == OP_CLEAR) begin
            gen_now = gen_now + 32'd1;
        end
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    // Keeps valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Registers are only written with the core idle. The spare index gets a
    // write too, which the core must ignore.
    task automatic configure(input logic [7:0] en, input logic [7:0] confirm,
                             input logic [7:0] max_hid);
        wait_idle();
        write_reg(CFG_ENABLED, en);
        write_reg(CFG_CONFIRM, confirm);
        write_reg(CFG_MAX_HID, max_hid);
        write_reg(CFG_UNUSED, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // One random item, mostly well-formed occluded/visible results and queries
    // on pool objects, with a share of transform changes, stale results,
    // mismatched queries, spare opcodes, clears and fresh objects.
    task automatic random_op();
        int          k;
        int          pick;
        logic [63:0] other;
        logic [31:0] stale;
        k     = $urandom_range(0, POOL - 1);
        pick  = $urandom_range(0, 99);
        other = {$urandom, $urandom};
        if (pick < 45) begin
            send_op(OP_APPLY, pool_key[k], pool_hash[k], 1'b0, gen_now);
        end else if (pick < 52) begin
            send_op(OP_APPLY, pool_key[k], pool_hash[k], 1'b1, gen_now);
        end else if (pick < 85) begin
            send_op(OP_QUERY, pool_key[k], pool_hash[k], 1'($urandom), 32'($urandom));
        end else if (pick < 88) begin
            if (other == pool_hash[k]) begin
                other = ~other;
            end
            send_op(OP_QUERY, pool_key[k], other, 1'($urandom), 32'($urandom));
        end else if (pick < 91) begin
            pool_hash[k] = other;
            send_op(OP_APPLY, pool_key[k], other, 1'($urandom), gen_now);
        end else if (pick < 94) begin
            stale = $urandom;
            if (stale == gen_now) begin
                stale = ~stale;
            end
            send_op(OP_APPLY, pool_key[k], pool_hash[k], 1'b0, stale);
        end else if (pick < 96) begin
            send_op(OP_UNDEF, other, {$urandom, $urandom}, 1'($urandom), 32'($urandom));
        end else if (pick < 97) begin
            send_op(OP_CLEAR, other, other, 1'($urandom), 32'($urandom));
        end else begin
            send_op(OP_APPLY, other, {$urandom, $urandom}, 1'b0, gen_now);
        end
    endtask

    // Result side: a random stall before each result, plus one long hold-off
    // on request while the item side keeps offering, so the core backs up.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Item side, register writes and the verdict.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ENABLED;
        i_cfg_data  = '0;
        for (int i = 0; i < POOL; i++) begin
            pool_key[i]  = {$urandom, $urandom};
            pool_hash[i] = {$urandom, $urandom};
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. With the history off after reset, queries draw and
        // results are dropped.
        send_op(OP_QUERY, pool_key[0], pool_hash[0], 1'b0, gen_now);
        send_op(OP_APPLY, pool_key[0], pool_hash[0], 1'b0, gen_now);

        // Limits written below their floor, so they act as 2 and 1.
        configure(8'h01, 8'h00, 8'h00);
        send_op(OP_APPLY, pool_key[0], pool_hash[0], 1'b0, gen_now);
        send_op(OP_QUERY, pool_key[0], pool_hash[0], 1'b0, gen_now);
        send_op(OP_APPLY, pool_key[0], pool_hash[0], 1'b0, gen_now);
        // Occlusion confirmed: the first query hides, the next forces a redraw.
        send_op(OP_QUERY, pool_key[0], pool_hash[0], 1'b0, gen_now);
        send_op(OP_QUERY, pool_key[0], pool_hash[0], 1'b0, gen_now);
        // A new transform restarts the entry, and a visible result clears it.
        send_op(OP_APPLY, pool_key[0], pool_hash[1], 1'b0, gen_now);
        send_op(OP_APPLY, pool_key[0], pool_hash[1], 1'b1, gen_now);
        // A result from an old generation is ignored.
        send_op(OP_APPLY, pool_key[0], pool_hash[1], 1'b0, ~gen_now);
        // A query with the wrong transform removes the entry; it is then missing.
        send_op(OP_QUERY, pool_key[0], pool_hash[2], 1'b1, gen_now);
        send_op(OP_QUERY, pool_key[0], pool_hash[1], 1'b1, gen_now);
        send_op(OP_UNDEF, '1, '1, 1'b1, '1);
        send_op(OP_APPLY, '1, '1, 1'b0, gen_now);
        send_op(OP_APPLY, '0, '0, 1'b1, gen_now);
        send_op(OP_QUERY, '1, '1, 1'b0, '1);
        send_op(OP_CLEAR, '0, '0, 1'b0, '0);
        // The clear made generation zero stale.
        send_op(OP_APPLY, '1, '1, 1'b0, gen_now - 32'd1);
        send_op(OP_APPLY, '1, '1, 1'b0, gen_now);
        send_op(OP_QUERY, '0, '0, 1'b0, gen_now);

        // Small limits, so hiding and forced redraws come often. Early on the
        // result side stalls for a long stretch, and later both sides run flat out.
        configure(8'h01, 8'd3, 8'd2);
        repeat (10) random_op();
        hold_out = 1'b1;
        repeat (50) random_op();
        no_idle = 1'b1;
        repeat (30) random_op();
        no_idle = 1'b0;
        repeat (30) random_op();

        // Largest limits.
        configure(8'h01, 8'hFF, 8'hFF);
        repeat (60) random_op();

        // History switched off through a write with bit 0 low.
        configure(8'hFE, 8'd4, 8'd1);
        repeat (20) random_op();

        // Random moderate limits with no idle cycles on either side.
        configure(8'h01, 8'($urandom_range(2, 6)), 8'($urandom_range(1, 4)));
        no_idle = 1'b1;
        repeat (40) random_op();
        no_idle = 1'b0;

        // Fill the table past capacity with distinct keys; the last applies
        // are dropped with the full flag. Queries look back at earlier keys.
        configure(8'h01, 8'h01, 8'h80);
        send_op(OP_CLEAR, '0, '0, 1'b0, '0);
        for (int i = 0; i < FILL_ITEMS; i++) begin
            fill_key[i]      = {$urandom, $urandom};
            fill_key[i][8:0] = i[8:0];
            fill_hash[i]     = {$urandom, $urandom};
            send_op(OP_APPLY, fill_key[i], fill_hash[i], 1'b0, gen_now);
            if (i % 16 == 15) begin
                send_op(OP_QUERY, fill_key[i - 8], fill_hash[i - 8], 1'b0, gen_now);
            end
        end
        // A key already present still updates on a full table.
        send_op(OP_APPLY, fill_key[0], fill_hash[0], 1'b0, gen_now);
        send_op(OP_QUERY, fill_key[0], fill_hash[0], 1'b0, gen_now);
        // Removing one entry frees exactly one slot for the next new key.
        send_op(OP_QUERY, fill_key[5], ~fill_hash[5], 1'b0, gen_now);
        send_op(OP_APPLY, fill_key[ENTRIES], fill_hash[ENTRIES], 1'b0, gen_now);
        send_op(OP_APPLY, fill_key[ENTRIES + 1], fill_hash[ENTRIES + 1], 1'b0,
                gen_now);
        send_op(OP_QUERY, fill_key[ENTRIES], fill_hash[ENTRIES], 1'b0, gen_now);

        // Let any stray result show up before the verdict.
        wait_idle();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
design/toht_pkg.sv
design/toht_ram.sv
design/temporal_occlusion_history_table_core.sv
design/toht_chk.sv
test/toht_history_check.sv
test/tb.sv
